>>> sv/assert_macros.svh
// Assertion macros shared by the rod cutting revenue block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/rcmr_pkg.sv
// Shared widths, limits and controller/datapath interface types for rod cutting.
package rcmr_pkg;

   localparam int PRICE_W = 16;
   localparam int REV_W   = 22;
   localparam logic [REV_W-1:0] REV_MAX = {REV_W{1'b1}};

   typedef struct packed {
      logic load;
      logic close;
      logic read;
      logic acc;
      logic wr;
   } rcmr_cmd_type;

   typedef struct packed {
      logic cut_last;
      logic len_last;
   } rcmr_status_type;

endpackage

>>> sv/rcmr_datapath.sv
// Datapath of the rod cutting block: price and revenue memories, counters, max unit.
`include "assert_macros.svh"

module rcmr_datapath
   import rcmr_pkg::*;
#(
   parameter int MAX_LENGTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rcmr_cmd_type           cmd,
   output rcmr_status_type        status,
   input  logic [PRICE_W-1:0]     req_piece_price,
   output logic [REV_W-1:0]       rsp_best_revenue
);

   localparam int CW = $clog2(MAX_LENGTH + 1);
   localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

   logic [PRICE_W-1:0] price_mem [MAX_LENGTH];
   logic [REV_W-1:0]   best_mem  [MAX_LENGTH];

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      len_ff, len_in;
   logic [CW-1:0]      cut_ff, cut_in;
   logic [PRICE_W-1:0] price_rd_ff;
   logic [REV_W-1:0]   best_rd_ff;
   logic               best_zero_ff;
   logic [REV_W-1:0]   top_ff, top_in;
   logic [REV_W-1:0]   result_ff;

   logic               full;
   logic [CW-1:0]      cut_m1;
   logic [CW-1:0]      rem_m1;
   logic [CW-1:0]      len_m1;
   logic [REV_W:0]     sum;
   logic [REV_W-1:0]   cand;

   assign full   = (count_ff == CW'(MAX_LENGTH));
   assign cut_m1 = cut_ff - CW'(1);
   assign rem_m1 = len_ff - cut_ff - CW'(1);
   assign len_m1 = len_ff - CW'(1);

   assign sum  = (REV_W+1)'(price_rd_ff) + (REV_W+1)'(best_zero_ff ? '0 : best_rd_ff);
   assign cand = sum[REV_W] ? REV_MAX : sum[REV_W-1:0];

   always_comb begin
      count_in = count_ff;
      n_in     = n_ff;
      len_in   = len_ff;
      cut_in   = cut_ff;
      top_in   = top_ff;
      if (cmd.close) begin
         count_in = '0;
         n_in     = full ? count_ff : count_ff + CW'(1);
         len_in   = CW'(1);
         cut_in   = CW'(1);
         top_in   = '0;
      end else if (cmd.load && !full) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.acc) begin
         cut_in = cut_ff + CW'(1);
         if (cand > top_ff) begin
            top_in = cand;
         end
      end
      if (cmd.wr) begin
         len_in = len_ff + CW'(1);
         cut_in = CW'(1);
         top_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         n_ff     <= '0;
         len_ff   <= '0;
         cut_ff   <= '0;
      end else begin
         count_ff <= count_in;
         n_ff     <= n_in;
         len_ff   <= len_in;
         cut_ff   <= cut_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (cmd.read) begin
         best_zero_ff <= (len_ff == cut_ff);
      end
      if (cmd.wr && status.len_last) begin
         result_ff <= top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         price_mem[count_ff[AW-1:0]] <= req_piece_price;
      end
      if (cmd.read) begin
         price_rd_ff <= price_mem[cut_m1[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         best_mem[len_m1[AW-1:0]] <= top_ff;
      end
      if (cmd.read) begin
         best_rd_ff <= best_mem[rem_m1[AW-1:0]];
      end
   end

   assign status.cut_last  = (cut_ff == len_ff);
   assign status.len_last  = (len_ff == n_ff);
   assign rsp_best_revenue = result_ff;

   `ASSERT_IMPLY(a_cut_in_range, cmd.acc, (cut_ff <= len_ff) && (cut_ff != '0), "cut length out of range")
   `ASSERT_IMPLY(a_len_in_range, cmd.wr, (len_ff <= n_ff) && (len_ff != '0), "rod length out of range")
   `ASSERT_NEXT(a_count_cleared, cmd.close, count_ff == '0, "price count not cleared after close")

endmodule

>>> sv/rcmr_controller.sv
// Controller state machine of the rod cutting block: request handshake and pass sequencing.
`include "assert_macros.svh"

module rcmr_controller
   import rcmr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last_price,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rcmr_cmd_type    cmd,
   input  rcmr_status_type status
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_ACC   = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_OUT   = 5'b10000
   } rcmr_state_type;

   rcmr_state_type state_ff, state_in;
   logic           take;

   assign req_stall = !((state_ff == ST_IDLE) ||
                        ((state_ff == ST_OUT) && (!req_last_price || !rsp_stall)));
   assign take      = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);

   assign cmd.load  = take;
   assign cmd.close = take && req_last_price;
   assign cmd.read  = (state_ff == ST_READ);
   assign cmd.acc   = (state_ff == ST_ACC);
   assign cmd.wr    = (state_ff == ST_WRITE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.close) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = status.cut_last ? ST_WRITE : ST_READ;
         end
         ST_WRITE: begin
            state_in = status.len_last ? ST_OUT : ST_READ;
         end
         ST_OUT: begin
            if (cmd.close) begin
               state_in = ST_READ;
            end else if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_read_then_acc, state_ff == ST_READ, state_ff == ST_ACC, "read not followed by accumulate")
   `ASSERT_NEXT(a_last_write_shows, cmd.wr && status.len_last, rsp_valid, "result not shown after final write")
   `ASSERT_IMPLY(a_busy_stalls, (state_ff != ST_IDLE) && (state_ff != ST_OUT), req_stall, "request taken during compute")

endmodule

>>> sv/rod_cutting_max_revenue_top.sv
// Rod cutting best revenue: a price request is stored when taken; the request marked
// last closes the rod of n prices (n at most MAX_LENGTH, further prices are dropped) and
// starts the revenue pass, in which each candidate cut first reads the price and revenue
// memories and then adds and compares. The result
// then waits in an output register; new prices may be loaded meanwhile, but the next
// closing request is held until that result is taken.
module rod_cutting_max_revenue_top
   import rcmr_pkg::*;
#(
   parameter int MAX_LENGTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [PRICE_W-1:0] req_piece_price,
   input  logic               req_last_price,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [REV_W-1:0]   rsp_best_revenue
);

   rcmr_cmd_type    cmd;
   rcmr_status_type status;

   rcmr_controller u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_price (req_last_price),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd),
      .status         (status)
   );

   rcmr_datapath #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_piece_price  (req_piece_price),
      .rsp_best_revenue (rsp_best_revenue)
   );

endmodule
